/* hw/rtl/iwca_pkg.sv */
`default_nettype none

package iwca_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_CELL_BITS = 32;

  // field widths
  localparam int TIME_W = 40;
  localparam int NODE_W = 6;
  localparam int CNT_W = 7;
  localparam int OUT_CELL_W = 32;

  // address field width of a queue entry, enough for the largest store
  localparam int ADDR_W_MAX = 20;

  // entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // command codes
  localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW_START = 2'd0;
  localparam logic [1:0] REG_WINDOW_END = 2'd1;
  localparam logic [1:0] REG_NODE_COUNT = 2'd2;
  localparam logic [1:0] REG_EXIT_NODE = 2'd3;

  typedef enum logic [2:0] {
    ST_COUNTED = 3'd0,
    ST_OUTSIDE = 3'd1,
    ST_RANGE = 3'd2,
    ST_EXIT = 3'd3,
    ST_READ = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  // what the back end has to do with an entry
  typedef enum logic [1:0] {
    OP_COUNT,
    OP_SKIP,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t op;
    status_t status;
    logic [TIME_W-1:0] overlap;
    logic [ADDR_W_MAX-1:0] addr_pair;
    logic [ADDR_W_MAX-1:0] addr_row;
    logic [ADDR_W_MAX-1:0] addr_col;
  } entry_t;

  typedef struct packed {
    logic signed [TIME_W-1:0] window_start;
    logic signed [TIME_W-1:0] window_end;
    logic [CNT_W-1:0] nodes_used;
    logic signed [CNT_W-1:0] exit_node;
  } cfg_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_CLASSIFY,
    FR_FINISH
  } front_state_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_READ,
    BK_WRITE,
    BK_FETCH,
    BK_LOOK,
    BK_SWEEP,
    BK_EMIT
  } back_state_t;

endpackage

`default_nettype wire

/* hw/rtl/iwca_queue.sv */
`default_nettype none

module iwca_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire iwca_pkg::entry_t push_entry,
  input  wire logic            pop,
  output iwca_pkg::entry_t     head,
  output logic                 full,
  output logic                 empty
);
  import iwca_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  entry_t slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_QW-1:0] fill;

  assign full = (fill == CNT_QW'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head = slots[rd_ptr];

  // pointer and fill bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/iwca_front.sv */
`default_nettype none

module iwca_front #(
  parameter int MAX_NODES = iwca_pkg::DEF_MAX_NODES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire iwca_pkg::cfg_t                  cfg,
  input  wire logic                            accept,
  input  wire logic [1:0]                      command,
  input  wire logic [iwca_pkg::TIME_W-1:0]     interval_start,
  input  wire logic [iwca_pkg::TIME_W-1:0]     interval_end,
  input  wire logic [iwca_pkg::NODE_W-1:0]     node_a,
  input  wire logic [iwca_pkg::NODE_W-1:0]     node_b,
  input  wire logic [iwca_pkg::NODE_W-1:0]     read_row,
  input  wire logic [iwca_pkg::NODE_W-1:0]     read_col,
  input  wire logic                            queue_full,
  output logic                                 front_busy,
  output logic                                 push,
  output iwca_pkg::entry_t                     push_entry
);
  import iwca_pkg::*;

  front_state_t state;
  front_state_t state_next;

  // captured command beat
  logic [1:0] cmd;
  logic signed [TIME_W-1:0] t_start;
  logic signed [TIME_W-1:0] t_end;
  logic [NODE_W-1:0] row;
  logic [NODE_W-1:0] col;
  logic [NODE_W-1:0] rd_row;
  logic [NODE_W-1:0] rd_col;

  // classification results
  op_t cls_op;
  status_t cls_status;
  logic signed [TIME_W-1:0] ov_start;
  logic signed [TIME_W-1:0] ov_end;
  logic [ADDR_W_MAX-1:0] addr_pair;
  logic [ADDR_W_MAX-1:0] addr_row;
  logic [ADDR_W_MAX-1:0] addr_col;

  // classify terms
  logic outside;
  logic row_ok;
  logic col_ok;
  logic exit_hit;
  logic rd_ok;
  op_t op_c;
  status_t status_c;

  // overlap length
  logic signed [TIME_W:0] dur;
  logic dur_pos;

  localparam logic [ADDR_W_MAX-1:0] STRIDE = ADDR_W_MAX'(MAX_NODES);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: begin
        if (accept) begin
          state_next = FR_CLASSIFY;
        end
      end
      FR_CLASSIFY: begin
        state_next = FR_FINISH;
      end
      FR_FINISH: begin
        if (!queue_full) begin
          state_next = FR_IDLE;
        end
      end
      default: state_next = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the beat, ordering the node pair
  always_ff @(posedge clk) begin
    if (state == FR_IDLE && accept) begin
      cmd <= command;
      t_start <= interval_start;
      t_end <= interval_end;
      row <= (node_a < node_b) ? node_a : node_b;
      col <= (node_a < node_b) ? node_b : node_a;
      rd_row <= read_row;
      rd_col <= read_col;
    end
  end

  // window, node range and exit node tests
  always_comb begin
    outside = (t_end <= cfg.window_start) || (t_start >= cfg.window_end);
    row_ok = (CNT_W'(row) < cfg.nodes_used) && (32'(row) < 32'(MAX_NODES));
    col_ok = (CNT_W'(col) < cfg.nodes_used) && (32'(col) < 32'(MAX_NODES));
    exit_hit = !cfg.exit_node[CNT_W-1] &&
               ((CNT_W'(row) == cfg.exit_node) || (CNT_W'(col) == cfg.exit_node));
    rd_ok = (32'(rd_row) < 32'(MAX_NODES)) && (32'(rd_col) < 32'(MAX_NODES));
    op_c = OP_READ;
    status_c = ST_READ;
    case (cmd)
      CMD_ACCUMULATE: begin
        op_c = OP_SKIP;
        if (outside) begin
          status_c = ST_OUTSIDE;
        end else if (!row_ok || !col_ok) begin
          status_c = ST_RANGE;
        end else if (exit_hit) begin
          status_c = ST_EXIT;
        end else begin
          op_c = OP_COUNT;
          status_c = ST_COUNTED;
        end
      end
      CMD_CLEAR: begin
        op_c = OP_CLEAR;
        status_c = ST_CLEARED;
      end
      default: begin
        op_c = rd_ok ? OP_READ : OP_SKIP;
        status_c = ST_READ;
      end
    endcase
  end

  // register the classification and the cell addresses
  always_ff @(posedge clk) begin
    if (state == FR_CLASSIFY) begin
      cls_op <= op_c;
      cls_status <= status_c;
      ov_start <= (t_start > cfg.window_start) ? t_start : cfg.window_start;
      ov_end <= (t_end < cfg.window_end) ? t_end : cfg.window_end;
      if (cmd == CMD_ACCUMULATE) begin
        addr_pair <= ADDR_W_MAX'(row) * STRIDE + ADDR_W_MAX'(col);
      end else begin
        addr_pair <= ADDR_W_MAX'(rd_row) * STRIDE + ADDR_W_MAX'(rd_col);
      end
      addr_row <= ADDR_W_MAX'(row) * STRIDE + ADDR_W_MAX'(row);
      addr_col <= ADDR_W_MAX'(col) * STRIDE + ADDR_W_MAX'(col);
    end
  end

  // overlap length; an empty overlap turns a counted edge into a skip
  assign dur = {ov_end[TIME_W-1], ov_end} - {ov_start[TIME_W-1], ov_start};
  assign dur_pos = !dur[TIME_W] && (dur != '0);

  always_comb begin
    push_entry.op = cls_op;
    push_entry.status = cls_status;
    push_entry.overlap = '0;
    push_entry.addr_pair = addr_pair;
    push_entry.addr_row = addr_row;
    push_entry.addr_col = addr_col;
    if (cls_op == OP_COUNT) begin
      if (dur_pos) begin
        push_entry.overlap = dur[TIME_W-1:0];
      end else begin
        push_entry.op = OP_SKIP;
        push_entry.status = ST_OUTSIDE;
      end
    end
  end

  assign push = (state == FR_FINISH) && !queue_full;
  assign front_busy = (state != FR_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/iwca_back.sv */
`default_nettype none

module iwca_back #(
  parameter int MAX_NODES = iwca_pkg::DEF_MAX_NODES,
  parameter int CELL_BITS = iwca_pkg::DEF_CELL_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              queue_empty,
  input  wire iwca_pkg::entry_t                  head,
  output logic                                   pop,
  output logic                                   init_busy,
  output logic                                   done,
  output logic [2:0]                             status,
  output logic [iwca_pkg::TIME_W-1:0]            overlap,
  output logic [iwca_pkg::OUT_CELL_W-1:0]        cell_value
);
  import iwca_pkg::*;

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = ((TIME_W > CELL_BITS) ? TIME_W : CELL_BITS) + 1;
  localparam logic [CELL_BITS-1:0] CELL_MAX = {CELL_BITS{1'b1}};

  back_state_t state;
  back_state_t state_next;

  entry_t ent;
  logic [1:0] step;
  logic [AW-1:0] sweep_addr;
  logic sweep_last;

  // single port store
  logic [CELL_BITS-1:0] mem [DEPTH];
  logic [CELL_BITS-1:0] rdata;
  logic mem_we;
  logic [AW-1:0] mem_addr;
  logic [CELL_BITS-1:0] mem_wdata;

  // saturating update
  logic [SW-1:0] add_val;
  logic [SW-1:0] sum;
  logic [CELL_BITS-1:0] sat_sum;
  logic [AW-1:0] step_addr;

  assign sweep_last = (sweep_addr == AW'(DEPTH - 1));
  assign pop = (state == BK_IDLE) && !queue_empty;
  assign init_busy = (state == BK_INIT);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_INIT: begin
        if (sweep_last) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!queue_empty) begin
          unique case (head.op)
            OP_COUNT: state_next = BK_READ;
            OP_READ:  state_next = BK_FETCH;
            OP_CLEAR: state_next = BK_SWEEP;
            default:  state_next = BK_EMIT;
          endcase
        end
      end
      BK_READ:  state_next = BK_WRITE;
      BK_WRITE: state_next = (step == 2'd2) ? BK_EMIT : BK_READ;
      BK_FETCH: state_next = BK_LOOK;
      BK_LOOK:  state_next = BK_IDLE;
      BK_SWEEP: begin
        if (sweep_last) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT:  state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_INIT;
    end else begin
      state <= state_next;
    end
  end

  // which of the three cells an edge is working on
  always_comb begin
    case (step)
      2'd0:    step_addr = AW'(ent.addr_pair);
      2'd1:    step_addr = AW'(ent.addr_row);
      default: step_addr = AW'(ent.addr_col);
    endcase
  end

  // add overlap to the pair cell, one to each diagonal cell
  always_comb begin
    add_val = (step == 2'd0) ? SW'(ent.overlap) : SW'(1);
    sum = SW'(rdata) + add_val;
    sat_sum = (sum > SW'(CELL_MAX)) ? CELL_MAX : CELL_BITS'(sum);
  end

  // memory controls
  always_comb begin
    mem_we = 1'b0;
    mem_addr = step_addr;
    mem_wdata = sat_sum;
    unique case (state)
      BK_INIT, BK_SWEEP: begin
        mem_we = 1'b1;
        mem_addr = sweep_addr;
        mem_wdata = '0;
      end
      BK_WRITE: begin
        mem_we = 1'b1;
      end
      BK_FETCH: begin
        mem_addr = AW'(ent.addr_pair);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else begin
      rdata <= mem[mem_addr];
    end
  end

  // step and sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      step <= '0;
    end else begin
      if (state == BK_INIT || state == BK_SWEEP) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      end
      if (state == BK_IDLE) begin
        step <= '0;
      end else if (state == BK_WRITE) begin
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= head;
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == BK_EMIT) || (state == BK_LOOK);
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_EMIT || state == BK_LOOK) begin
      status <= ent.status;
      overlap <= ent.overlap;
      cell_value <= (state == BK_LOOK) ? OUT_CELL_W'(rdata) : '0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/interval_window_contact_accumulator.sv */
`default_nettype none

// Contact matrix accumulator. Commands enter on start when busy is low; every
// command gives exactly one result, shown for one cycle with done high, and the
// receiver cannot stall it. A front end captures the command, runs the
// window/node tests, then the overlap subtract, and hands it through a
// two-entry queue to a back end that owns the single-port cell store. A counted
// edge takes the back end through three read-then-write passes on the one
// memory port between pop and result, a read one memory fetch, a rejected
// edge none, and a clear a zeroing sweep of all MAX_NODES*MAX_NODES cells.
// After reset the store is zeroed by the same sweep, during which busy stays
// high; configuration writes are taken at any time (cfg_ready is always high)
// and must only be made while no command is in flight.
module interval_window_contact_accumulator #(
  parameter int MAX_NODES = iwca_pkg::DEF_MAX_NODES,
  parameter int CELL_BITS = iwca_pkg::DEF_CELL_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        command,
  input  wire logic [iwca_pkg::TIME_W-1:0]       interval_start,
  input  wire logic [iwca_pkg::TIME_W-1:0]       interval_end,
  input  wire logic [iwca_pkg::NODE_W-1:0]       node_a,
  input  wire logic [iwca_pkg::NODE_W-1:0]       node_b,
  input  wire logic [iwca_pkg::NODE_W-1:0]       read_row,
  input  wire logic [iwca_pkg::NODE_W-1:0]       read_col,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [iwca_pkg::TIME_W-1:0]       cfg_data,
  output logic                                   done,
  output logic [2:0]                             status,
  output logic [iwca_pkg::TIME_W-1:0]            overlap,
  output logic [iwca_pkg::OUT_CELL_W-1:0]        cell_value
);
  import iwca_pkg::*;

  cfg_t cfg;
  logic front_busy;
  logic init_busy;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_empty;
  entry_t push_entry;
  entry_t head;

  assign cfg_ready = 1'b1;
  assign busy = front_busy || init_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_start <= '0;
      cfg.window_end <= '0;
      cfg.nodes_used <= CNT_W'(64);
      cfg.exit_node <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_START: cfg.window_start <= cfg_data;
        REG_WINDOW_END:   cfg.window_end <= cfg_data;
        REG_NODE_COUNT:   cfg.nodes_used <= cfg_data[CNT_W-1:0];
        REG_EXIT_NODE:    cfg.exit_node <= cfg_data[CNT_W-1:0];
        default:          cfg.exit_node <= cfg.exit_node;
      endcase
    end
  end

  iwca_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .accept(start && !busy),
    .command(command),
    .interval_start(interval_start),
    .interval_end(interval_end),
    .node_a(node_a),
    .node_b(node_b),
    .read_row(read_row),
    .read_col(read_col),
    .queue_full(queue_full),
    .front_busy(front_busy),
    .push(push),
    .push_entry(push_entry)
  );

  iwca_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_entry(push_entry),
    .pop(pop),
    .head(head),
    .full(queue_full),
    .empty(queue_empty)
  );

  iwca_back #(
    .MAX_NODES(MAX_NODES),
    .CELL_BITS(CELL_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .queue_empty(queue_empty),
    .head(head),
    .pop(pop),
    .init_busy(init_busy),
    .done(done),
    .status(status),
    .overlap(overlap),
    .cell_value(cell_value)
  );

endmodule

`default_nettype wire
